>>> src/bclf_pkg.sv
// ----------------------------------------------------------------------------
// bclf_pkg
// Shared constants, types and helpers for the button combo lock filter.
// ----------------------------------------------------------------------------
package bclf_pkg;

    localparam int NUM_BUTTONS  = 4;
    localparam int HOLD_WIDTH   = 16;
    localparam int BTN_INDEX_W  = 2;
    localparam int HOLD_TICKS_W = 16;
    localparam int COMBO_W      = 4;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [COMBO_W-1:0] COMBO_RESET = COMBO_W'(9);

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMBO_MASK = 1'b1;

    localparam logic [63:0] HOLD_MAX64 = (64'd1 << HOLD_WIDTH) - 64'd1;

    typedef logic [NUM_BUTTONS-1:0] btn_mask_t;
    typedef logic [HOLD_WIDTH-1:0]  hold_cnt_t;

    typedef struct packed {
        logic                   action;
        logic [BTN_INDEX_W-1:0] btn_index;
        logic                   is_down;
        logic                   watchface_running;
    } bclf_item_t;

    typedef struct packed {
        logic swallow;
        logic locked;
        logic toggled;
        logic show_hint;
        logic reset_clicks;
        logic cancel_quit;
    } bclf_result_t;

    // hold time as loaded into the countdown, saturated for a narrow counter
    function automatic hold_cnt_t hold_load(input logic [HOLD_TICKS_W-1:0] ticks);
        logic [63:0] wide;
        wide = 64'(ticks);
        if (wide > HOLD_MAX64)
            wide = HOLD_MAX64;
        return hold_cnt_t'(wide);
    endfunction

    // combo mask restricted to the buttons that exist
    function automatic btn_mask_t combo_to_mask(input logic [COMBO_W-1:0] combo);
        logic [63:0] wide;
        wide = 64'(combo);
        return btn_mask_t'(wide);
    endfunction

endpackage

>>> src/bclf_core.sv
// ----------------------------------------------------------------------------
// bclf_core
// Lock state, button tracking, hold countdown and config registers; computes
// the result of one item and updates the state when the item is taken.
// ----------------------------------------------------------------------------
module bclf_core
    import bclf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   go,
    input  bclf_item_t             item,
    output bclf_result_t           result
);

    logic [HOLD_TICKS_W-1:0] hold_ticks_reg;
    logic [COMBO_W-1:0]      combo_mask_reg;
    btn_mask_t               held_reg, held_next;
    btn_mask_t               delivered_reg, delivered_next;
    logic                    pending_reg, pending_next;
    logic                    consumed_reg, consumed_next;
    logic                    lock_reg, lock_next;
    hold_cnt_t               remain_reg, remain_next;
    logic                    running_reg, running_next;

    always_comb
    begin
        btn_mask_t bit_m;
        logic      combo_match;
        logic      done;
        logic      id_ok;

        held_next      = held_reg;
        delivered_next = delivered_reg;
        pending_next   = pending_reg;
        consumed_next  = consumed_reg;
        lock_next      = lock_reg;
        remain_next    = remain_reg;
        running_next   = running_reg;
        result         = '0;
        bit_m          = btn_mask_t'(1) << item.btn_index;
        combo_match    = 1'b0;
        done           = 1'b0;
        id_ok          = 32'(item.btn_index) < NUM_BUTTONS;

        if (item.action) begin
            if (running_reg) begin
                if (remain_reg != '0)
                    remain_next = remain_reg - hold_cnt_t'(1);
                if (remain_next == '0) begin
                    running_next = 1'b0;
                    if (pending_reg) begin
                        consumed_next  = 1'b1;
                        lock_next      = !lock_reg;
                        result.toggled = 1'b1;
                    end
                end
            end
        end else if (id_ok) begin
            held_next = item.is_down ? (held_reg | bit_m) : (held_reg & ~bit_m);
            if (held_next == '0)
                consumed_next = 1'b0;

            combo_match = (held_next == combo_to_mask(combo_mask_reg)) &&
                          !consumed_next && (hold_ticks_reg != '0);

            if (combo_match && !pending_reg) begin
                // combo completed: start countdown, swallow the completing event
                pending_next        = 1'b1;
                result.cancel_quit  = 1'b1;
                result.reset_clicks = !lock_reg && item.watchface_running;
                remain_next         = hold_load(hold_ticks_reg);
                running_next        = 1'b1;
                result.swallow      = 1'b1;
                done                = 1'b1;
            end else if (!combo_match && pending_reg) begin
                pending_next = 1'b0;
                running_next = 1'b0;
                remain_next  = '0;
            end

            if (!done) begin
                if (item.is_down) begin
                    if (lock_reg || pending_next) begin
                        result.show_hint = lock_reg && !pending_next;
                        result.swallow   = 1'b1;
                    end else begin
                        delivered_next = delivered_reg | bit_m;
                    end
                end else begin
                    result.swallow = (delivered_reg & bit_m) == '0;
                    delivered_next = delivered_reg & ~bit_m;
                end
            end
        end

        result.locked = lock_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_ticks_reg <= '0;
            combo_mask_reg <= COMBO_RESET;
            held_reg       <= '0;
            delivered_reg  <= '0;
            pending_reg    <= 1'b0;
            consumed_reg   <= 1'b0;
            lock_reg       <= 1'b0;
            remain_reg     <= '0;
            running_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HOLD_TICKS: hold_ticks_reg <= cfg_data[HOLD_TICKS_W-1:0];
                    CFG_COMBO_MASK: combo_mask_reg <= cfg_data[COMBO_W-1:0];
                    default: ;
                endcase
            end
            if (go) begin
                held_reg      <= held_next;
                delivered_reg <= delivered_next;
                pending_reg   <= pending_next;
                consumed_reg  <= consumed_next;
                lock_reg      <= lock_next;
                remain_reg    <= remain_next;
                running_reg   <= running_next;
            end
        end
    end

endmodule

>>> src/button_combo_lock_filter.sv
// ----------------------------------------------------------------------------
// button_combo_lock_filter
// Button event filter with a hold-to-lock combo and tick-driven countdown.
// ----------------------------------------------------------------------------
// Takes one item (button event or timer tick) per clock while in_stall is
// low and returns exactly one result per item. An item is registered in the
// input register on acceptance, evaluated against the lock state when it
// advances and lands in the result register, so a new item can be taken
// while the last is still in flight; the only loop is the state update in
// the core. Input stall rises only while both the input and the result
// register hold an item and the result is stalled. cfg_ready is always high;
// write configuration only while no item is in flight.
module button_combo_lock_filter
    import bclf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic [BTN_INDEX_W-1:0] btn_index,
    input  logic                   is_down,
    input  logic                   watchface_running,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   swallow,
    output logic                   locked,
    output logic                   toggled,
    output logic                   show_hint,
    output logic                   reset_clicks,
    output logic                   cancel_quit,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic         in_vld_reg, in_vld_next;
    bclf_item_t   item_reg;
    logic         out_vld_reg, out_vld_next;
    bclf_result_t res_reg;
    bclf_result_t core_res;
    logic         out_free;
    logic         adv;
    logic         in_take;

    assign out_free    = !out_vld_reg || !out_stall;
    assign adv         = in_vld_reg && out_free;
    assign in_stall    = in_vld_reg && !out_free;
    assign in_take     = in_valid && !in_stall;
    assign in_vld_next = in_take || (in_vld_reg && !adv);
    assign out_vld_next = adv || (out_vld_reg && out_stall);
    assign cfg_ready   = 1'b1;

    bclf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .go        (adv),
        .item      (item_reg),
        .result    (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= '{action: action, btn_index: btn_index,
                          is_down: is_down, watchface_running: watchface_running};
        if (adv)
            res_reg <= core_res;
    end

    assign out_valid    = out_vld_reg;
    assign swallow      = res_reg.swallow;
    assign locked       = res_reg.locked;
    assign toggled      = res_reg.toggled;
    assign show_hint    = res_reg.show_hint;
    assign reset_clicks = res_reg.reset_clicks;
    assign cancel_quit  = res_reg.cancel_quit;

endmodule

>>> src/bclf_checker.sv
// ----------------------------------------------------------------------------
// bclf_checker
// Port-level checks for the button combo lock filter, bound to the top level.
// ----------------------------------------------------------------------------
module bclf_checker
    import bclf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic swallow,
    input logic locked,
    input logic toggled,
    input logic show_hint,
    input logic reset_clicks,
    input logic cancel_quit
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(swallow) && $stable(locked)
            && $stable(toggled) && $stable(show_hint))
        else $error("stalled result changed");

    // a lock toggle only comes from a tick, which carries no event flags
    a_toggle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && toggled |-> !swallow && !show_hint && !reset_clicks && !cancel_quit)
        else $error("toggle on a button event");

    // the hint is requested only for a swallowed press while locked
    a_hint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && show_hint |-> locked && swallow && !cancel_quit)
        else $error("hint while unlocked");

    // combo start swallows the completing event; click reset only when unlocked
    a_combo_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reset_clicks |-> cancel_quit && swallow && !locked)
        else $error("click reset outside combo start");

endmodule

bind button_combo_lock_filter bclf_checker u_bclf_checker (.*);
